// File: sv/erc_pkg.sv
`timescale 1ns / 1ps

package erc_pkg;

    localparam int NUM_FLOORS  = 4;
    localparam int NUM_BUTTONS = 3;
    localparam int FLOOR_W     = $clog2(NUM_FLOORS);
    localparam int REQ_W       = NUM_FLOORS * NUM_BUTTONS;

    // event codes
    localparam logic [2:0] EV_TABLE        = 3'd0;
    localparam logic [2:0] EV_ARRIVAL      = 3'd1;
    localparam logic [2:0] EV_DOOR_TIMEOUT = 3'd2;
    localparam logic [2:0] EV_FLOOR_TIMEOUT = 3'd3;
    localparam logic [2:0] EV_STOP_PRESS   = 3'd4;
    localparam logic [2:0] EV_STOP_RELEASE = 3'd5;

    // motor and inertia directions
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // timer commands
    localparam logic [1:0] TMR_NONE  = 2'd0;
    localparam logic [1:0] TMR_START = 2'd1;
    localparam logic [1:0] TMR_STOP  = 2'd2;

    // reported motion codes
    localparam logic [1:0] MC_IDLE   = 2'd0;
    localparam logic [1:0] MC_MOVING = 2'd1;
    localparam logic [1:0] MC_DOOR   = 2'd2;

    typedef enum logic [2:0] {
        MV_IDLE   = 3'b001,
        MV_MOVING = 3'b010,
        MV_DOOR   = 3'b100
    } t_motion;

    typedef struct packed {
        logic [2:0]         func;
        logic [FLOOR_W-1:0] sensor_floor;
        logic               at_floor;
        logic [REQ_W-1:0]   request_bits;
        logic               obstructed;
    } t_item;

    typedef struct packed {
        t_motion            motion;
        logic [1:0]         inertia;
        logic               halted;
        logic               door_open;
        logic               fault;
        logic [FLOOR_W-1:0] floor;
        logic               door_running;
        logic [1:0]         motor;
    } t_state;

    typedef struct packed {
        logic [1:0]         motion_state;
        logic [2:0]         clear_mask;
        logic [1:0]         floor_timer_cmd;
        logic [1:0]         door_timer_cmd;
        logic [FLOOR_W-1:0] floor_shown;
        logic               fault_flag;
        logic               stop_lamp;
        logic               door_is_open;
        logic [1:0]         motor_cmd;
    } t_result;

    typedef struct packed {
        logic                   above;
        logic                   here;
        logic                   below;
        logic [NUM_BUTTONS-1:0] btn;
    } t_floor_info;

    typedef struct packed {
        logic [1:0] dir;
        t_motion    mv;
    } t_decision;

    function automatic t_floor_info analyze(input logic [REQ_W-1:0] reqs,
                                            input logic [FLOOR_W-1:0] f);
        t_floor_info info;
        logic        here_g;
        info = '0;
        for (int g = 0; g < NUM_FLOORS; g++) begin
            here_g = |reqs[g*NUM_BUTTONS +: NUM_BUTTONS];
            if (g > int'(f)) begin
                info.above = info.above | here_g;
            end else if (g < int'(f)) begin
                info.below = info.below | here_g;
            end else begin
                info.here = here_g;
                info.btn  = reqs[g*NUM_BUTTONS +: NUM_BUTTONS];
            end
        end
        return info;
    endfunction

    function automatic t_decision choose(input logic [1:0] inertia, input t_floor_info fi);
        t_decision d;
        d.dir = DIR_STOP;
        d.mv  = MV_IDLE;
        if (inertia == DIR_UP) begin
            if (fi.above) begin
                d.dir = DIR_UP;
                d.mv  = MV_MOVING;
            end else if (fi.here) begin
                d.mv = MV_DOOR;
            end else if (fi.below) begin
                d.dir = DIR_DOWN;
                d.mv  = MV_MOVING;
            end
        end else if (inertia == DIR_DOWN) begin
            if (fi.below) begin
                d.dir = DIR_DOWN;
                d.mv  = MV_MOVING;
            end else if (fi.here) begin
                d.mv = MV_DOOR;
            end else if (fi.above) begin
                d.dir = DIR_UP;
                d.mv  = MV_MOVING;
            end
        end else if (inertia == DIR_STOP) begin
            if (fi.here) begin
                d.mv = MV_DOOR;
            end else if (fi.above) begin
                d.dir = DIR_UP;
                d.mv  = MV_MOVING;
            end else if (fi.below) begin
                d.dir = DIR_DOWN;
                d.mv  = MV_MOVING;
            end
        end
        return d;
    endfunction

    function automatic logic should_stop(input logic [1:0] inertia, input t_floor_info fi);
        logic s;
        if (inertia == DIR_DOWN) begin
            s = fi.btn[1] | fi.btn[2] | ~fi.below;
        end else if (inertia == DIR_UP) begin
            s = fi.btn[0] | fi.btn[2] | ~fi.above;
        end else begin
            s = 1'b1;
        end
        return s;
    endfunction

    function automatic logic [2:0] clear_here(input logic [1:0] inertia, input t_floor_info fi);
        logic [2:0] m;
        m = 3'b100;
        if (inertia == DIR_UP) begin
            m[0] = 1'b1;
            if (!fi.above && !fi.btn[0]) m[1] = 1'b1;
        end else if (inertia == DIR_DOWN) begin
            m[1] = 1'b1;
            if (!fi.below && !fi.btn[1]) m[0] = 1'b1;
        end else begin
            m[1:0] = 2'b11;
        end
        return m;
    endfunction

endpackage

// File: sv/erc_core.sv
`timescale 1ns / 1ps

module erc_core (
    input  erc_pkg::t_item   i_item,
    input  erc_pkg::t_state  i_state,
    output erc_pkg::t_state  o_state,
    output erc_pkg::t_result o_result
);

    erc_pkg::t_state                 st;
    erc_pkg::t_floor_info            info;
    erc_pkg::t_decision              dec;
    erc_pkg::t_decision              exec_dec;
    logic                            do_exec;
    logic [erc_pkg::FLOOR_W-1:0]     sf_sat;
    logic [erc_pkg::FLOOR_W-1:0]     f_eff;
    logic [1:0]                      door_cmd;
    logic [1:0]                      floor_cmd;
    logic [2:0]                      mask;
    logic                            stop_here;
    logic [2:0]                      clr;
    logic [1:0]                      motion_code;

    always_comb begin
        sf_sat = (int'(i_item.sensor_floor) >= erc_pkg::NUM_FLOORS)
               ? erc_pkg::FLOOR_W'(erc_pkg::NUM_FLOORS - 1) : i_item.sensor_floor;
        f_eff  = (i_item.func == erc_pkg::EV_ARRIVAL && i_item.at_floor) ? sf_sat
               : i_state.floor;
        info      = erc_pkg::analyze(i_item.request_bits, f_eff);
        dec       = erc_pkg::choose(i_state.inertia, info);
        stop_here = erc_pkg::should_stop(i_state.inertia, info);
        clr       = erc_pkg::clear_here(i_state.inertia, info);
    end

    always_comb begin
        st        = i_state;
        door_cmd  = erc_pkg::TMR_NONE;
        floor_cmd = erc_pkg::TMR_NONE;
        mask      = 3'b000;
        do_exec   = 1'b0;
        exec_dec  = dec;
        unique case (i_item.func)
            erc_pkg::EV_TABLE: begin
                if (i_state.motion == erc_pkg::MV_DOOR) begin
                    if (stop_here) begin
                        st.door_running = 1'b1;
                        door_cmd        = erc_pkg::TMR_START;
                        mask            = clr;
                    end
                end else if (i_state.motion == erc_pkg::MV_IDLE) begin
                    if (dec.mv == erc_pkg::MV_DOOR) begin
                        st.door_open    = 1'b1;
                        st.door_running = 1'b1;
                        door_cmd        = erc_pkg::TMR_START;
                        do_exec         = 1'b1;
                        mask            = clr;
                    end else if (i_item.obstructed) begin
                        if (!i_state.door_running) begin
                            st.door_running = 1'b1;
                            door_cmd        = erc_pkg::TMR_START;
                        end
                    end else begin
                        st.door_open = 1'b0;
                        do_exec      = 1'b1;
                    end
                end
            end
            erc_pkg::EV_ARRIVAL: begin
                st.floor  = f_eff;
                st.fault  = 1'b0;
                floor_cmd = erc_pkg::TMR_START;
                if (i_state.motion == erc_pkg::MV_MOVING && stop_here) begin
                    st.motor        = erc_pkg::DIR_STOP;
                    st.door_open    = 1'b1;
                    st.door_running = 1'b1;
                    door_cmd        = erc_pkg::TMR_START;
                    floor_cmd       = erc_pkg::TMR_STOP;
                    st.motion       = erc_pkg::MV_DOOR;
                    mask            = clr;
                end
            end
            erc_pkg::EV_DOOR_TIMEOUT: begin
                st.door_running = 1'b0;
                door_cmd        = erc_pkg::TMR_STOP;
                if (i_item.obstructed) begin
                    st.door_running = 1'b1;
                    door_cmd        = erc_pkg::TMR_START;
                end else if (i_state.motion == erc_pkg::MV_DOOR) begin
                    do_exec = 1'b1;
                    if (dec.mv == erc_pkg::MV_DOOR) begin
                        st.door_running = 1'b1;
                        door_cmd        = erc_pkg::TMR_START;
                        mask            = clr;
                    end else begin
                        st.door_open = 1'b0;
                    end
                end
            end
            erc_pkg::EV_FLOOR_TIMEOUT: begin
                floor_cmd = erc_pkg::TMR_STOP;
                if (i_state.motion == erc_pkg::MV_MOVING) st.fault = 1'b1;
            end
            erc_pkg::EV_STOP_PRESS: begin
                st.halted = 1'b1;
                st.motor  = erc_pkg::DIR_STOP;
                if (i_item.at_floor) begin
                    st.door_open    = 1'b1;
                    st.door_running = 1'b1;
                    door_cmd        = erc_pkg::TMR_START;
                end
                st.motion = erc_pkg::MV_IDLE;
                floor_cmd = erc_pkg::TMR_STOP;
            end
            erc_pkg::EV_STOP_RELEASE: begin
                st.halted = 1'b0;
                if (i_state.door_open) begin
                    st.motion       = erc_pkg::MV_DOOR;
                    st.door_running = 1'b1;
                    door_cmd        = erc_pkg::TMR_START;
                    mask            = clr;
                end else begin
                    do_exec = 1'b1;
                    if (i_state.inertia == erc_pkg::DIR_UP) begin
                        exec_dec.dir = erc_pkg::DIR_UP;
                        exec_dec.mv  = erc_pkg::MV_MOVING;
                    end else if (i_state.inertia == erc_pkg::DIR_DOWN) begin
                        exec_dec.dir = erc_pkg::DIR_DOWN;
                        exec_dec.mv  = erc_pkg::MV_MOVING;
                    end else begin
                        exec_dec.dir = erc_pkg::DIR_STOP;
                        exec_dec.mv  = erc_pkg::MV_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase
        // direction decision takes effect only when not halted
        if (do_exec && !st.halted) begin
            st.motor  = exec_dec.dir;
            st.motion = exec_dec.mv;
            floor_cmd = (exec_dec.mv == erc_pkg::MV_MOVING) ? erc_pkg::TMR_START
                                                            : erc_pkg::TMR_STOP;
            if (exec_dec.dir != erc_pkg::DIR_STOP) st.inertia = exec_dec.dir;
        end
    end

    always_comb begin
        unique case (st.motion)
            erc_pkg::MV_MOVING: motion_code = erc_pkg::MC_MOVING;
            erc_pkg::MV_DOOR:   motion_code = erc_pkg::MC_DOOR;
            default:            motion_code = erc_pkg::MC_IDLE;
        endcase
    end

    assign o_state = st;

    always_comb begin
        o_result.motor_cmd       = st.motor;
        o_result.door_is_open    = st.door_open;
        o_result.stop_lamp       = st.halted;
        o_result.fault_flag      = st.fault;
        o_result.floor_shown     = st.floor;
        o_result.door_timer_cmd  = door_cmd;
        o_result.floor_timer_cmd = floor_cmd;
        o_result.clear_mask      = mask;
        o_result.motion_state    = motion_code;
    end

endmodule

// File: sv/elevator_request_controller.sv
`timescale 1ns / 1ps

// Single-car elevator controller. Each transfer on the slave stream is one event (kind in
// s_axis_tuser) carrying the full request table, floor sensor and obstruction switch; each
// event produces exactly one result transfer with motor, door, lamp, timer commands and the
// mask of buttons served at the current floor. One event is taken every clock cycle while the
// master stream accepts results (m_axis_tready high); a result is offered on the master stream
// once its event has passed from the input register through the combinational core into the
// result register, and the controller state updates in the same cycle as its result, so
// back-to-back events see each other's effects in order. The output register lets the next
// event enter while a result waits for m_axis_tready.

module elevator_request_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // sensor_floor[1:0], at_floor, request_bits[11:0], obstructed
    input  logic [2:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // motor_cmd[1:0], door_is_open, stop_lamp, fault_flag,
                                        // floor_shown[1:0], door_timer_cmd[1:0],
                                        // floor_timer_cmd[1:0], clear_mask[2:0], motion_state[1:0]
);

    logic             r_in_valid;
    erc_pkg::t_item   r_in;
    erc_pkg::t_state  r_state;
    erc_pkg::t_state  n_state;
    logic             r_out_valid;
    erc_pkg::t_result r_out;
    erc_pkg::t_result n_out;
    logic             advance;
    erc_pkg::t_item   s_item;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = i_rst_n && (!r_in_valid || advance);

    always_comb begin
        s_item.func         = s_axis_tuser;
        s_item.sensor_floor = s_axis_tdata[1:0];
        s_item.at_floor     = s_axis_tdata[2];
        s_item.request_bits = s_axis_tdata[14:3];
        s_item.obstructed   = s_axis_tdata[15];
    end

    erc_core u_core (
        .i_item   (r_in),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= s_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.motion       <= erc_pkg::MV_IDLE;
            r_state.inertia      <= erc_pkg::DIR_STOP;
            r_state.halted       <= 1'b0;
            r_state.door_open    <= 1'b0;
            r_state.fault        <= 1'b0;
            r_state.floor        <= '0;
            r_state.door_running <= 1'b0;
            r_state.motor        <= erc_pkg::DIR_STOP;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

// File: sv/erc_checker.sv
`timescale 1ns / 1ps

module erc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // motor runs exactly when moving
    a_motor_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[15:14] == erc_pkg::MC_MOVING)
                           == (m_axis_tdata[1:0] != erc_pkg::DIR_STOP)))
        else $error("motor and motion state disagree");

    // never moving with door open or stop lamp on
    a_moving_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[15:14] == erc_pkg::MC_MOVING
        |-> !m_axis_tdata[2] && !m_axis_tdata[3])
        else $error("moving with door open or halted");

    // a served floor always clears its cab button
    a_clear_cab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[13:11] != 3'd0 |-> m_axis_tdata[13])
        else $error("clear mask without cab button");

endmodule

bind elevator_request_controller erc_checker u_erc_checker (.*);
